@@ rtl/sha1sh_pkg.sv @@
`default_nettype none

package sha1sh_pkg;

   // Widths of the hash datapath.
   localparam int unsigned WORD_W     = 32;
   localparam int unsigned CHAIN_N    = 5;
   localparam int unsigned BLOCK_N    = 16;
   localparam int unsigned ROUND_N    = 80;
   localparam int unsigned LENGTH_W   = 64;

   // Initial chaining value, entry 0 in the lowest slice.
   localparam logic [CHAIN_N-1:0][WORD_W-1:0] CHAIN_INIT = {
      32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
   };

   // First padding byte.
   localparam logic [7:0] PAD_BYTE = 8'h80;

   // Index of the final digest word.
   localparam logic [2:0] LAST_INDEX = 3'd4;

   // Control from the sequencer to the round datapath.
   typedef struct packed {
      logic       load;
      logic       step;
      logic [2:0] load_idx;
      logic [6:0] round_idx;
   } round_ctl_type;

endpackage

`default_nettype wire

@@ rtl/sha1sh_round.sv @@
`default_nettype none

module sha1sh_round
   import sha1sh_pkg::*;
(
   input  wire logic                             clock,
   input  wire round_ctl_type                    ctl,
   input  wire logic [WORD_W-1:0]                load_word,
   input  wire logic [WORD_W-1:0]                msg_word,
   output logic      [CHAIN_N-1:0][WORD_W-1:0]   state_words
);

   localparam logic [WORD_W-1:0] K0 = 32'h5a827999;
   localparam logic [WORD_W-1:0] K1 = 32'h6ed9eba1;
   localparam logic [WORD_W-1:0] K2 = 32'h8f1bbcdc;
   localparam logic [WORD_W-1:0] K3 = 32'hca62c1d6;

   // Working variables a to e, and the last sixteen schedule words (entry 15 newest).
   logic [CHAIN_N-1:0][WORD_W-1:0] rr_ff;
   logic [BLOCK_N-1:0][WORD_W-1:0] sched_ff;

   logic [WORD_W-1:0] a, b, c, d, e;
   logic [WORD_W-1:0] mix_word;
   logic [WORD_W-1:0] sched_word;
   logic [WORD_W-1:0] f_word;
   logic [WORD_W-1:0] k_word;
   logic [WORD_W-1:0] temp_word;

   assign a = rr_ff[0];
   assign b = rr_ff[1];
   assign c = rr_ff[2];
   assign d = rr_ff[3];
   assign e = rr_ff[4];

   // Schedule: the first sixteen words come from the block buffer, later ones expand.
   assign mix_word   = sched_ff[13] ^ sched_ff[8] ^ sched_ff[2] ^ sched_ff[0];
   assign sched_word = (ctl.round_idx < 7'd16) ? msg_word : {mix_word[30:0], mix_word[31]};

   // Round function and constant by group of twenty rounds.
   always_comb begin
      if (ctl.round_idx < 7'd20) begin
         f_word = (b & c) | (~b & d);
         k_word = K0;
      end else if (ctl.round_idx < 7'd40) begin
         f_word = b ^ c ^ d;
         k_word = K1;
      end else if (ctl.round_idx < 7'd60) begin
         f_word = (b & c) | (b & d) | (c & d);
         k_word = K2;
      end else begin
         f_word = b ^ c ^ d;
         k_word = K3;
      end
   end

   assign temp_word = {a[26:0], a[31:27]} + f_word + e + sched_word + k_word;

   // Load from the chaining value, or advance one round.
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         rr_ff[ctl.load_idx] <= load_word;
      end else if (ctl.step) begin
         rr_ff[4] <= d;
         rr_ff[3] <= c;
         rr_ff[2] <= {b[1:0], b[31:2]};
         rr_ff[1] <= a;
         rr_ff[0] <= temp_word;
         sched_ff <= {sched_word, sched_ff[BLOCK_N-1:1]};
      end
   end

   assign state_words = rr_ff;

endmodule

`default_nettype wire

@@ rtl/sha1_stream_hasher_unit.sv @@
`default_nettype none

// SHA-1 hasher that takes a message one byte per input word. req_tuser marks
// whether req_tdata carries a message byte; req_tlast ends the message after
// that word's byte, and the 160-bit digest then leaves as five result words,
// most significant first, with rsp_tlast on the fifth. Every 64th byte starts
// a compression (load of the chaining value from its memory, 80 rounds at one
// per cycle, add back), during which no input word is taken. The end of a
// message writes up to 18 padding words to the block memory and adds one or
// two compressions. The digest drains from its own output registers, so the
// next message is taken while the last digest is still being read; a digest
// that is ready to leave waits only if the previous one has not fully drained.
module sha1_stream_hasher_unit
   import sha1sh_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tuser,   // [0] byte_valid
   input  wire logic        req_tlast,   // end_of_message
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [39:0] rsp_tdata,   // [31:0] digest_word, [34:32] word_index, [39:35] zero
   output logic             rsp_tlast    // last_word
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_LOAD,
      ST_ROUND,
      ST_ADD
   } state_type;

   // Places one byte big-endian into a partly filled word.
   function automatic logic [WORD_W-1:0] merge_byte(logic [WORD_W-1:0] acc, logic [1:0] pos,
                                                    logic [7:0] val);
      logic [WORD_W-1:0] w;
      begin
         w = (pos == 2'd0) ? '0 : acc;
         case (pos)
            2'd0:    w[31:24] = val;
            2'd1:    w[23:16] = val;
            2'd2:    w[15:8]  = val;
            2'd3:    w[7:0]   = val;
            default: w = acc;
         endcase
         return w;
      end
   endfunction

   // Control registers.
   state_type                       state_ff, state_in;
   logic [6:0]                      cnt_ff, cnt_in;
   logic [5:0]                      fill_ff, fill_in;
   logic [LENGTH_W-1:0]             bits_ff, bits_in;
   logic                            pad_act_ff, pad_act_in;
   logic                            pad_first_ff, pad_first_in;
   logic                            len_ff, len_in;
   logic                            fin_ff, fin_in;
   logic [CHAIN_N-1:0]              chain_vld_ff, chain_vld_in;
   logic [2:0]                      out_cnt_ff, out_cnt_in;
   logic [2:0]                      out_idx_ff, out_idx_in;

   // Payload registers.
   logic [WORD_W-1:0]               acc_ff, acc_in;
   logic [CHAIN_N-1:0][WORD_W-1:0]  dig_ff, dig_in;

   // Block buffer and chaining value memories.
   logic [WORD_W-1:0]               blk_mem [BLOCK_N];
   logic [WORD_W-1:0]               blk_q_ff;
   logic                            blk_we;
   logic [3:0]                      blk_wa;
   logic [3:0]                      blk_ra;
   logic [WORD_W-1:0]               blk_wd;

   logic [WORD_W-1:0]               chain_mem [CHAIN_N];
   logic [WORD_W-1:0]               chain_q_ff;
   logic [2:0]                      chain_ridx_ff;
   logic                            chain_we;
   logic [2:0]                      chain_wa;
   logic [2:0]                      chain_ra;
   logic [WORD_W-1:0]               chain_wd;
   logic [WORD_W-1:0]               chain_rd;

   round_ctl_type                   round_ctl;
   logic [CHAIN_N-1:0][WORD_W-1:0]  round_words;

   logic                            req_accept;
   logic                            rsp_accept;
   logic [WORD_W-1:0]               byte_word;
   logic [3:0]                      widx;
   logic [2:0]                      slot;
   logic [WORD_W-1:0]               sum_word;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = (out_cnt_ff != 3'd0);
   assign rsp_accept = rsp_tvalid && rsp_tready;
   assign rsp_tdata  = {5'd0, out_idx_ff, dig_ff[0]};
   assign rsp_tlast  = (out_idx_ff == LAST_INDEX);

   assign byte_word = merge_byte(acc_ff, fill_ff[1:0], req_tdata);
   assign widx      = fill_ff[5:2];
   assign slot      = cnt_ff[2:0] - 3'd1;

   // A chaining entry not written since reset or the end of the last message reads as the initial value.
   assign chain_rd = chain_vld_ff[chain_ridx_ff] ? chain_q_ff : CHAIN_INIT[chain_ridx_ff];
   assign sum_word = chain_rd + round_words[slot];

   // Next-state and memory control.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      fill_in      = fill_ff;
      bits_in      = bits_ff;
      pad_act_in   = pad_act_ff;
      pad_first_in = pad_first_ff;
      len_in       = len_ff;
      fin_in       = fin_ff;
      chain_vld_in = chain_vld_ff;
      out_cnt_in   = out_cnt_ff;
      out_idx_in   = out_idx_ff;
      acc_in       = acc_ff;
      dig_in       = dig_ff;
      blk_we       = 1'b0;
      blk_wa       = widx;
      blk_wd       = '0;
      blk_ra       = 4'd0;
      chain_we     = 1'b0;
      chain_wa     = slot;
      chain_wd     = sum_word;
      chain_ra     = 3'd0;
      round_ctl    = '0;

      // Digest words leave from the front of the output registers.
      if (rsp_accept) begin
         dig_in     = {{WORD_W{1'b0}}, dig_ff[CHAIN_N-1:1]};
         out_cnt_in = out_cnt_ff - 3'd1;
         out_idx_in = out_idx_ff + 3'd1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_tuser) begin
                  acc_in  = byte_word;
                  bits_in = bits_ff + 64'd8;
                  fill_in = fill_ff + 6'd1;
                  if (fill_ff[1:0] == 2'd3) begin
                     blk_we = 1'b1;
                     blk_wd = byte_word;
                  end
               end
               if (req_tlast) begin
                  pad_act_in   = 1'b1;
                  pad_first_in = 1'b1;
                  len_in       = 1'b0;
               end
               if (req_tuser && (fill_ff == 6'd63)) begin
                  fin_in   = 1'b0;
                  cnt_in   = 7'd0;
                  state_in = ST_LOAD;
               end else if (req_tlast) begin
                  state_in = ST_PAD;
               end
            end
         end

         // One padding word per cycle: the marker byte, zeros, then the bit length.
         ST_PAD: begin
            blk_we = 1'b1;
            if (pad_first_ff) begin
               blk_wd       = merge_byte(acc_ff, fill_ff[1:0], PAD_BYTE);
               pad_first_in = 1'b0;
               fill_in      = {widx + 4'd1, 2'b00};
               if (widx == 4'd15) begin
                  fin_in   = 1'b0;
                  cnt_in   = 7'd0;
                  state_in = ST_LOAD;
               end
            end else if ((widx == 4'd15) && len_ff) begin
               blk_wd   = bits_ff[31:0];
               fin_in   = 1'b1;
               cnt_in   = 7'd0;
               state_in = ST_LOAD;
            end else if (widx == 4'd14) begin
               blk_wd  = bits_ff[63:32];
               len_in  = 1'b1;
               fill_in = fill_ff + 6'd4;
            end else begin
               blk_wd  = '0;
               fill_in = fill_ff + 6'd4;
               if (widx == 4'd15) begin
                  fin_in   = 1'b0;
                  cnt_in   = 7'd0;
                  state_in = ST_LOAD;
               end
            end
         end

         // Chaining value into the working variables; first block word is fetched last.
         ST_LOAD: begin
            chain_ra = (cnt_ff < 7'd5) ? cnt_ff[2:0] : 3'd0;
            if (cnt_ff != 7'd0) begin
               round_ctl.load     = 1'b1;
               round_ctl.load_idx = slot;
            end
            if (cnt_ff == 7'd5) begin
               cnt_in   = 7'd0;
               state_in = ST_ROUND;
            end else begin
               cnt_in = cnt_ff + 7'd1;
            end
         end

         // One round per cycle, prefetching the next block word.
         ST_ROUND: begin
            round_ctl.step      = 1'b1;
            round_ctl.round_idx = cnt_ff;
            blk_ra              = cnt_ff[3:0] + 4'd1;
            if (cnt_ff == 7'(ROUND_N - 1)) begin
               cnt_in   = 7'd0;
               state_in = ST_ADD;
            end else begin
               cnt_in = cnt_ff + 7'd1;
            end
         end

         // Read, add and write back each chaining word; a final block also fills the digest.
         ST_ADD: begin
            chain_ra = (cnt_ff < 7'd5) ? cnt_ff[2:0] : 3'd0;
            if (!(fin_ff && (out_cnt_ff != 3'd0) && (cnt_ff == 7'd0))) begin
               cnt_in = cnt_ff + 7'd1;
               if (cnt_ff != 7'd0) begin
                  chain_we           = 1'b1;
                  chain_vld_in[slot] = 1'b1;
                  if (fin_ff) begin
                     dig_in[slot] = sum_word;
                  end
               end
               if (cnt_ff == 7'd5) begin
                  cnt_in = 7'd0;
                  if (fin_ff) begin
                     out_cnt_in   = 3'(CHAIN_N);
                     out_idx_in   = 3'd0;
                     chain_vld_in = '0;
                     fill_in      = 6'd0;
                     bits_in      = '0;
                     pad_act_in   = 1'b0;
                     state_in     = ST_IDLE;
                  end else if (pad_act_ff) begin
                     state_in = ST_PAD;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= 7'd0;
         fill_ff      <= 6'd0;
         bits_ff      <= '0;
         pad_act_ff   <= 1'b0;
         pad_first_ff <= 1'b0;
         len_ff       <= 1'b0;
         fin_ff       <= 1'b0;
         chain_vld_ff <= '0;
         out_cnt_ff   <= 3'd0;
         out_idx_ff   <= 3'd0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         fill_ff      <= fill_in;
         bits_ff      <= bits_in;
         pad_act_ff   <= pad_act_in;
         pad_first_ff <= pad_first_in;
         len_ff       <= len_in;
         fin_ff       <= fin_in;
         chain_vld_ff <= chain_vld_in;
         out_cnt_ff   <= out_cnt_in;
         out_idx_ff   <= out_idx_in;
      end
      acc_ff <= acc_in;
      dig_ff <= dig_in;
   end

   // Block buffer: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (blk_we) begin
         blk_mem[blk_wa] <= blk_wd;
      end
      blk_q_ff <= blk_mem[blk_ra];
   end

   // Chaining value: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (chain_we) begin
         chain_mem[chain_wa] <= chain_wd;
      end
      chain_q_ff    <= chain_mem[chain_ra];
      chain_ridx_ff <= chain_ra;
   end

   sha1sh_round u_round (
      .clock       (clock),
      .ctl         (round_ctl),
      .load_word   (chain_rd),
      .msg_word    (blk_q_ff),
      .state_words (round_words)
   );

endmodule

`default_nettype wire

@@ rtl/sha1sh_checker.sv @@
`default_nettype none

module sha1sh_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [39:0] rsp_tdata,
   input wire logic        rsp_tlast
);

   // A stalled digest word stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("digest word withdrawn while stalled");

   // A stalled digest word holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("digest word changed while stalled");

   // The last flag marks exactly the fifth word.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tdata[34:32] == 3'd4)))
      else $error("last flag not on word four");

   // Within a digest the words follow one another without a gap.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         rsp_tvalid && (rsp_tdata[34:32] == $past(rsp_tdata[34:32]) + 3'd1))
      else $error("digest words out of sequence");

   // Reset leaves nothing to deliver.
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered after reset");

endmodule

bind sha1_stream_hasher_unit sha1sh_checker u_checker (.*);

`default_nettype wire

@@ bench/tb_sha1_stream_hasher_unit.sv @@
`timescale 1ns / 1ps

// Testbench for the SHA-1 stream hasher. Messages go in one byte per input
// word. A local hash model tracks the chaining value, the partial block and
// the bit count, and queues the five digest words that each end of message
// must produce. Every result word is checked against the oldest queued one.
module tb_sha1_stream_hasher_unit
   import sha1sh_pkg::*;
();

   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned DRAIN_CYCLES = 300;
   localparam int unsigned IDLE_PCT     = 15;
   localparam int unsigned RANDOM_ITEMS = 40;

   // Round constants, one for each group of 20 rounds.
   localparam logic [31:0] ROUND_K0 = 32'h5a827999;
   localparam logic [31:0] ROUND_K1 = 32'h6ed9eba1;
   localparam logic [31:0] ROUND_K2 = 32'h8f1bbcdc;
   localparam logic [31:0] ROUND_K3 = 32'hca62c1d6;

   // One digest word as it should appear on the result channel.
   typedef struct packed {
      logic [31:0] value;
      logic [2:0]  position;
      logic        is_last;
   } digest_beat_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;  // [7:0] data_byte
   logic        req_tuser  = 1'b0;   // [0] byte_valid
   logic        req_tlast  = 1'b0;   // end_of_message
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;           // [31:0] digest_word, [34:32] word_index
   logic        rsp_tlast;           // last_word

   // Hash model state.
   logic [31:0] chain_st [CHAIN_N];
   logic [31:0] block_st [BLOCK_N];
   int unsigned fill_st;
   logic [63:0] bit_count_st;

   digest_beat_type digest_q [$];
   int unsigned     error_count = 0;
   int unsigned     cycle_count = 0;
   int unsigned     item_count  = 0;
   bit              steady_run  = 1'b0;

   sha1_stream_hasher_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #2 clock = ~clock;

   // Return the hash model to its state after reset.
   function automatic void hash_restart();
      for (int i = 0; i < CHAIN_N; i++) begin
         chain_st[i] = CHAIN_INIT[i];
      end
      for (int i = 0; i < BLOCK_N; i++) begin
         block_st[i] = '0;
      end
      fill_st      = 0;
      bit_count_st = '0;
   endfunction

   // Run the 80-round compression on the current block.
   function automatic void fold_block();
      logic [31:0] sched [BLOCK_N];
      logic [31:0] a, b, c, d, e, f, k, w, sum;
      sched = block_st;
      a = chain_st[0];
      b = chain_st[1];
      c = chain_st[2];
      d = chain_st[3];
      e = chain_st[4];
      for (int t = 0; t < ROUND_N; t++) begin
         if (t < 16) begin
            w = sched[t];
         end else begin
            w = sched[(t - 3) & 15] ^ sched[(t - 8) & 15] ^ sched[(t - 14) & 15]
                ^ sched[t & 15];
            w = {w[30:0], w[31]};
            sched[t & 15] = w;
         end
         case (t / 20)
            0: begin
               f = (b & c) | (~b & d);
               k = ROUND_K0;
            end
            1: begin
               f = b ^ c ^ d;
               k = ROUND_K1;
            end
            2: begin
               f = (b & c) | (b & d) | (c & d);
               k = ROUND_K2;
            end
            default: begin
               f = b ^ c ^ d;
               k = ROUND_K3;
            end
         endcase
         sum = {a[26:0], a[31:27]} + f + e + w + k;
         e = d;
         d = c;
         c = {b[1:0], b[31:2]};
         b = a;
         a = sum;
      end
      chain_st[0] += a;
      chain_st[1] += b;
      chain_st[2] += c;
      chain_st[3] += d;
      chain_st[4] += e;
   endfunction

   // Pack one byte big-endian into the block; a full block is compressed.
   function automatic void absorb_byte(input logic [7:0] data);
      int unsigned shift;
      shift = (3 - (fill_st % 4)) * 8;
      if (fill_st % 4 == 0) begin
         block_st[fill_st / 4] = 32'(data) << shift;
      end else begin
         block_st[fill_st / 4] |= 32'(data) << shift;
      end
      fill_st++;
      if (fill_st == 64) begin
         fold_block();
         fill_st = 0;
      end
   endfunction

   // Update the model with one accepted input word and queue any digest.
   function automatic void predict_digest(input logic [7:0] data, input logic byte_valid,
                                          input logic end_msg);
      digest_beat_type beat;
      if (byte_valid) begin
         bit_count_st += 64'd8;
         absorb_byte(data);
      end
      if (end_msg) begin
         absorb_byte(PAD_BYTE);
         while (fill_st != 56) begin
            absorb_byte(8'h00);
         end
         block_st[14] = bit_count_st[63:32];
         block_st[15] = bit_count_st[31:0];
         fold_block();
         for (int i = 0; i < CHAIN_N; i++) begin
            beat.value    = chain_st[i];
            beat.position = 3'(i);
            beat.is_last  = (3'(i) == LAST_INDEX);
            digest_q.push_back(beat);
         end
         hash_restart();
      end
   endfunction

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // The receiver stalls now and then, except during the steady stretch.
   always @(posedge clock) begin
      rsp_tready <= steady_run || ($urandom_range(99) >= IDLE_PCT);
   end

   // Compare each accepted digest word with the oldest expected one.
   always @(posedge clock) begin
      digest_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (digest_q.size() == 0) begin
            $display("%0t: unexpected digest word %h index %0d last %b", $time,
                     rsp_tdata[31:0], rsp_tdata[34:32], rsp_tlast);
            error_count++;
         end else begin
            want = digest_q.pop_front();
            if (rsp_tdata[31:0] !== want.value || rsp_tdata[34:32] !== want.position ||
                rsp_tlast !== want.is_last) begin
               $display("%0t: digest mismatch: expected %h index %0d last %b, got %h index %0d last %b",
                        $time, want.value, want.position, want.is_last,
                        rsp_tdata[31:0], rsp_tdata[34:32], rsp_tlast);
               error_count++;
            end
         end
      end
   end

   // Present one input word, with an optional random gap before it, and
   // update the model once it has been taken.
   task automatic send_word(input logic [7:0] data, input logic byte_valid,
                            input logic end_msg);
      while (!steady_run && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= byte_valid;
      req_tlast  <= end_msg;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      predict_digest(data, byte_valid, end_msg);
      if (byte_valid || end_msg) begin
         item_count++;
      end
   endtask

   // Send a message of random bytes, with stray empty words mixed in. The
   // end is marked on the last byte or by a separate word without a byte.
   task automatic send_message(input int unsigned length);
      bit end_on_byte;
      end_on_byte = (length > 0) && $urandom_range(1);
      for (int unsigned i = 0; i < length; i++) begin
         if ($urandom_range(99) < 10) begin
            send_word(8'($urandom), 1'b0, 1'b0);
         end
         send_word(8'($urandom), 1'b1, end_on_byte && (i == length - 1));
      end
      if (!end_on_byte) begin
         send_word(8'($urandom), 1'b0, 1'b1);
      end
   endtask

   // Hold the sender until every queued digest word has arrived.
   task automatic wait_for_digests();
      req_tvalid <= 1'b0;
      do begin
         @(posedge clock);
      end while (digest_q.size() != 0);
   endtask

   // An end word alone hashes the empty message.
   task automatic test_empty_message();
      send_word(8'hff, 1'b0, 1'b1);
   endtask

   // The classic three-byte message, ended on its last byte.
   task automatic test_abc_message();
      send_word(8'h61, 1'b1, 1'b0);
      send_word(8'h62, 1'b1, 1'b0);
      send_word(8'h63, 1'b1, 1'b1);
   endtask

   // Extreme byte values, ignored data on empty words, and an end without byte.
   task automatic test_extreme_bytes();
      send_word(8'h00, 1'b1, 1'b0);
      send_word(8'hff, 1'b0, 1'b0);
      send_word(8'hff, 1'b1, 1'b0);
      send_word(8'h80, 1'b1, 1'b0);
      send_word(8'h00, 1'b0, 1'b0);
      send_word(8'hff, 1'b0, 1'b1);
   endtask

   // Messages ended back to back, so digests queue up behind each other.
   task automatic test_back_to_back_ends();
      send_word(8'h00, 1'b0, 1'b1);
      send_word(8'h00, 1'b0, 1'b1);
      send_word(8'h5a, 1'b1, 1'b1);
      send_word(8'ha5, 1'b1, 1'b1);
   endtask

   // Padding that needs a second block, and a full block followed by a
   // padding-only block, all without any idling.
   task automatic test_padding_boundaries();
      steady_run = 1'b1;
      send_message(56);
      send_message(64);
      steady_run = 1'b0;
   endtask

   // Mostly short messages, with some that end close to the block boundary.
   task automatic test_random_messages();
      int unsigned stop_at;
      int unsigned pick;
      stop_at = item_count + RANDOM_ITEMS;
      while (item_count < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 10) begin
            send_message($urandom_range(55, 63));
         end else begin
            send_message($urandom_range(0, 12));
         end
      end
   endtask

   initial begin
      hash_restart();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_message();
      test_abc_message();
      test_extreme_bytes();
      test_back_to_back_ends();
      wait_for_digests();
      test_padding_boundaries();
      test_random_messages();

      // Let every digest drain, then watch for stray words.
      wait_for_digests();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
